// ===== rtl/bba_pkg.sv =====
// Shared types, constants and node-summary helpers for the buddy block allocator.
// Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int TOTAL_BLOCKS_LOG2_DEF = 10;
  localparam int MAX_ALLOC_LOG2_DEF    = 6;

  localparam logic [3:0] BS_RESET = 4'd4;
  localparam logic [3:0] BS_MIN   = 4'd2;
  localparam logic [3:0] BS_MAX   = 4'd12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Node summary codes
  localparam logic [4:0] NODE_FREE    = 5'h00;
  localparam logic [4:0] NODE_USED    = 5'h02;
  localparam logic [4:0] NODE_FRAG    = 5'h03;
  localparam logic [4:0] NODE_PARTIAL = 5'h10;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LARGE = 3'd1,
    ERR_NO_SPACE  = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_MISALIGN  = 3'd4,
    ERR_NOT_START = 3'd5,
    ERR_NOT_ALLOC = 3'd6
  } err_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_KINC, OP_SCAN_INIT, OP_RD_ROOT, OP_SCAN_EVAL,
    OP_DESC_INIT, OP_RD_NODE, OP_RD_LEFT, OP_RD_RIGHT, OP_WR_LFREE, OP_WR_RFREE,
    OP_PICK, OP_WR_USED, OP_UP, OP_WR_REFRESH, OP_FREE_INIT, OP_F_DESC,
    OP_WR_FREE, OP_ERR, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SIZE, S_SCAN_RD, S_SCAN_EV, S_A_NODE, S_A_SPLIT, S_A_WRR,
    S_A_RDR, S_A_PICK, S_UP_CHK, S_UP_RDL, S_UP_RDR, S_UP_WR, S_F_CHK, S_F_NODE,
    S_F_EVAL, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    err_t   err;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic k_over;
    logic k_more;
    logic scan_done;
    logic best_valid;
    logic at_target;
    logic node_free;
    logic node_used;
    logic level_zero;
    logic start_bad;
    logic at_top;
    logic range_err;
    logic align_err;
    logic out_busy;
  } dp_status_t;

  // Largest free block as log2 plus an exists flag
  typedef struct packed {
    logic       ex;
    logic [4:0] lg;
  } lfb_t;

  function automatic lfb_t lfb_of(logic [4:0] v, logic [4:0] level);
    lfb_t f;
    f = '0;
    if (v[4]) begin
      f.ex = 1'b1;
      f.lg = {1'b0, v[3:0]};
    end else if (v == NODE_FREE) begin
      f.ex = 1'b1;
      f.lg = level;
    end
    return f;
  endfunction

  function automatic logic lfb_le(lfb_t a, lfb_t b);
    return !a.ex || (b.ex && (a.lg <= b.lg));
  endfunction

  function automatic logic lfb_fits(lfb_t a, logic [4:0] k);
    return a.ex && (a.lg >= k);
  endfunction

  function automatic logic [4:0] refresh_code(lfb_t l, lfb_t r);
    lfb_t m;
    m = lfb_le(l, r) ? r : l;
    if (!m.ex) return NODE_FRAG;
    return NODE_PARTIAL | {1'b0, m.lg[3:0]};
  endfunction

endpackage

// ===== rtl/bba_ctrl.sv =====
// Sequencer for the buddy block allocator: one state machine issuing datapath commands.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  bba_pkg::dp_status_t st,
  output bba_pkg::dp_cmd_t    cmd
);
  import bba_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: OP_NONE, err: ERR_NONE};
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = (in_command == CMD_FREE) ? S_F_CHK : S_SIZE;
        end
      end
      S_SIZE: begin
        if (st.k_over) begin
          cmd = '{op: OP_ERR, err: ERR_TOO_LARGE};
          state_nxt = S_DONE;
        end else if (st.k_more) begin
          cmd.op = OP_KINC;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (st.scan_done) begin
          if (st.best_valid) begin
            cmd.op    = OP_DESC_INIT;
            state_nxt = S_A_NODE;
          end else begin
            cmd = '{op: OP_ERR, err: ERR_NO_SPACE};
            state_nxt = S_DONE;
          end
        end else begin
          cmd.op    = OP_RD_ROOT;
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.op    = OP_SCAN_EVAL;
        state_nxt = S_SCAN_RD;
      end
      S_A_NODE: begin
        if (st.at_target) begin
          cmd.op    = OP_WR_USED;
          state_nxt = S_UP_CHK;
        end else begin
          cmd.op    = OP_RD_NODE;
          state_nxt = S_A_SPLIT;
        end
      end
      S_A_SPLIT: begin
        if (st.node_free) begin
          cmd.op    = OP_WR_LFREE;
          state_nxt = S_A_WRR;
        end else begin
          cmd.op    = OP_RD_LEFT;
          state_nxt = S_A_RDR;
        end
      end
      S_A_WRR: begin
        cmd.op    = OP_WR_RFREE;
        state_nxt = S_A_NODE;
      end
      S_A_RDR: begin
        cmd.op    = OP_RD_RIGHT;
        state_nxt = S_A_PICK;
      end
      S_A_PICK: begin
        cmd.op    = OP_PICK;
        state_nxt = S_A_NODE;
      end
      S_UP_CHK: begin
        if (st.at_top) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_UP;
          state_nxt = S_UP_RDL;
        end
      end
      S_UP_RDL: begin
        cmd.op    = OP_RD_LEFT;
        state_nxt = S_UP_RDR;
      end
      S_UP_RDR: begin
        cmd.op    = OP_RD_RIGHT;
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.op    = OP_WR_REFRESH;
        state_nxt = S_UP_CHK;
      end
      S_F_CHK: begin
        if (st.range_err) begin
          cmd = '{op: OP_ERR, err: ERR_RANGE};
          state_nxt = S_DONE;
        end else if (st.align_err) begin
          cmd = '{op: OP_ERR, err: ERR_MISALIGN};
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_FREE_INIT;
          state_nxt = S_F_NODE;
        end
      end
      S_F_NODE: begin
        cmd.op    = OP_RD_NODE;
        state_nxt = S_F_EVAL;
      end
      S_F_EVAL: begin
        if (st.node_used) begin
          if (st.start_bad) begin
            cmd = '{op: OP_ERR, err: ERR_NOT_START};
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_WR_FREE;
            state_nxt = S_UP_CHK;
          end
        end else if (st.node_free || st.level_zero) begin
          cmd = '{op: OP_ERR, err: ERR_NOT_ALLOC};
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_F_DESC;
          state_nxt = S_F_NODE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: node summary memory, walk registers,
// byte accounting and the result register. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_datapath #(
  parameter int TOTAL_BLOCKS_LOG2 = bba_pkg::TOTAL_BLOCKS_LOG2_DEF,
  parameter int MAX_ALLOC_LOG2    = bba_pkg::MAX_ALLOC_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bba_pkg::dp_cmd_t    cmd,
  output bba_pkg::dp_status_t st,
  input  logic                cfg_write_en,
  input  logic [3:0]          cfg_write_data,
  input  logic                in_command,
  input  logic [31:0]         in_size_bytes,
  input  logic [31:0]         in_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic [2:0]          out_error_code,
  output logic [27:0]         out_address,
  output logic [28:0]         out_moved_bytes,
  output logic [28:0]         out_used_total
);
  import bba_pkg::*;

  localparam int TOP        = (MAX_ALLOC_LOG2 < TOTAL_BLOCKS_LOG2) ? MAX_ALLOC_LOG2
                                                                    : TOTAL_BLOCKS_LOG2;
  localparam int RW         = TOTAL_BLOCKS_LOG2 - TOP;
  localparam int RIW        = (RW > 0) ? RW : 1;
  localparam int ROOT_COUNT = 1 << RW;
  localparam int TREE_NODES = (1 << (TOP + 1)) - 1;
  localparam int NODE_COUNT = ROOT_COUNT * TREE_NODES;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int HW         = TOP + 1;
  localparam logic [4:0] TOP_L = 5'(TOP);
  localparam logic [5:0] TBL_L = 6'(TOTAL_BLOCKS_LOG2);

  logic [4:0] mem [NODE_COUNT];
  logic [4:0] mem_q_r;

  logic [3:0]      bs_cfg_r, bs_r;
  logic            cmd_free_r;
  logic [31:0]     size_r, off_r;
  logic [4:0]      k_r, level_r, left_r;
  logic [RW:0]     root_cnt_r;
  logic [AW-1:0]   base_r, best_base_r;
  logic [RIW-1:0]  best_root_r;
  logic            best_valid_r;
  logic [4:0]      best_lg_r;
  logic [HW-1:0]   heap_r;
  logic [TOP-1:0]  path_r, local_r;
  logic [27:0]     addr_r;
  logic [28:0]     moved_r, used_r;
  err_t            err_r;
  logic            out_valid_r, out_ok_r;
  err_t            out_err_r;
  logic [27:0]     out_address_r;
  logic [28:0]     out_moved_r, out_used_r;

  logic [AW-1:0]   node_addr, left_addr, right_addr;
  logic            rd_en, we;
  logic [AW-1:0]   raddr, waddr;
  logic [4:0]      wdata;
  lfb_t            lfb_root, lfb_l, lfb_r;
  logic            side;
  logic [TOP-1:0]  lmask, lshift;
  logic [31:0]     blk_idx;
  logic [RIW-1:0]  free_root;
  logic [31:0]     grant_bytes, rel_bytes;
  logic [27:0]     blk_addr;

  assign node_addr  = base_r + AW'(heap_r) - AW'(1);
  assign left_addr  = base_r + (AW'(heap_r) << 1) - AW'(1);
  assign right_addr = base_r + (AW'(heap_r) << 1);

  assign lfb_root = lfb_of(mem_q_r, TOP_L);
  assign lfb_l    = lfb_of(left_r, level_r - 5'd1);
  assign lfb_r    = lfb_of(mem_q_r, level_r - 5'd1);
  assign side     = (lfb_le(lfb_l, lfb_r) && lfb_fits(lfb_l, k_r)) ? 1'b0 :
                    (!lfb_fits(lfb_r, k_r)) ? 1'b0 : 1'b1;

  assign lmask     = (TOP'(1) << level_r) - TOP'(1);
  assign lshift    = local_r >> (level_r - 5'd1);
  assign blk_idx   = off_r >> bs_r;
  assign free_root = RIW'(blk_idx >> TOP);

  assign grant_bytes = 32'd1 << ({1'b0, k_r} + {2'b0, bs_r});
  assign rel_bytes   = 32'd1 << ({1'b0, level_r} + {2'b0, bs_r});
  assign blk_addr    = ((28'(best_root_r) << TOP) | (28'(path_r) << k_r)) << bs_r;

  // Memory port control
  always_comb begin
    rd_en = 1'b0;
    raddr = node_addr;
    we    = 1'b0;
    waddr = node_addr;
    wdata = NODE_FREE;
    case (cmd.op)
      OP_RD_ROOT:  begin rd_en = 1'b1; raddr = base_r; end
      OP_RD_NODE:  rd_en = 1'b1;
      OP_RD_LEFT:  begin rd_en = 1'b1; raddr = left_addr; end
      OP_RD_RIGHT: begin rd_en = 1'b1; raddr = right_addr; end
      OP_CLEAR:    begin we = 1'b1; waddr = base_r; end
      OP_WR_LFREE: begin we = 1'b1; waddr = left_addr; end
      OP_WR_RFREE: begin we = 1'b1; waddr = right_addr; end
      OP_WR_USED:  begin we = 1'b1; wdata = NODE_USED; end
      OP_WR_FREE:  we = 1'b1;
      OP_WR_REFRESH: begin
        we = 1'b1;
        if (cmd_free_r && left_r == NODE_FREE && mem_q_r == NODE_FREE) begin
          wdata = NODE_FREE;
        end else begin
          wdata = refresh_code(lfb_l, lfb_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_cfg_r    <= BS_RESET;
      used_r      <= '0;
      base_r      <= '0;
      root_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) bs_cfg_r <= cfg_write_data;
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR, OP_SCAN_EVAL: begin
          base_r     <= base_r + AW'(TREE_NODES);
          root_cnt_r <= root_cnt_r + 1'b1;
        end
        OP_SCAN_INIT: begin
          base_r     <= '0;
          root_cnt_r <= '0;
        end
        OP_DESC_INIT: base_r <= best_base_r;
        OP_FREE_INIT: base_r <= AW'(free_root) * AW'(TREE_NODES);
        OP_WR_USED:   used_r <= used_r + grant_bytes[28:0];
        OP_WR_FREE:   used_r <= (used_r >= rel_bytes[28:0]) ? used_r - rel_bytes[28:0]
                                                            : '0;
        default: ;
      endcase
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_free_r <= in_command;
        size_r     <= in_size_bytes;
        off_r      <= in_offset;
        bs_r       <= (bs_cfg_r < BS_MIN) ? BS_MIN : (bs_cfg_r > BS_MAX) ? BS_MAX : bs_cfg_r;
        k_r        <= '0;
        err_r      <= ERR_NONE;
        addr_r     <= '0;
        moved_r    <= '0;
      end
      OP_KINC:      k_r <= k_r + 5'd1;
      OP_SCAN_INIT: best_valid_r <= 1'b0;
      OP_SCAN_EVAL: begin
        if (lfb_fits(lfb_root, k_r) && (!best_valid_r || lfb_root.lg < best_lg_r)) begin
          best_valid_r <= 1'b1;
          best_root_r  <= root_cnt_r[RIW-1:0];
          best_base_r  <= base_r;
          best_lg_r    <= lfb_root.lg;
        end
      end
      OP_DESC_INIT: begin
        heap_r  <= HW'(1);
        level_r <= TOP_L;
        path_r  <= '0;
      end
      OP_FREE_INIT: begin
        heap_r  <= HW'(1);
        level_r <= TOP_L;
        local_r <= blk_idx[TOP-1:0];
      end
      OP_RD_RIGHT: left_r <= mem_q_r;
      OP_WR_RFREE: begin
        heap_r  <= heap_r << 1;
        level_r <= level_r - 5'd1;
        path_r  <= path_r << 1;
      end
      OP_PICK: begin
        heap_r  <= {heap_r[HW-2:0], side};
        level_r <= level_r - 5'd1;
        path_r  <= {path_r[TOP-2:0], side};
      end
      OP_F_DESC: begin
        heap_r  <= {heap_r[HW-2:0], lshift[0]};
        level_r <= level_r - 5'd1;
      end
      OP_UP: begin
        heap_r  <= heap_r >> 1;
        level_r <= level_r + 5'd1;
      end
      OP_WR_USED: begin
        addr_r  <= blk_addr;
        moved_r <= grant_bytes[28:0];
      end
      OP_WR_FREE: moved_r <= rel_bytes[28:0];
      OP_ERR:     err_r <= cmd.err;
      OP_EMIT: begin
        out_ok_r      <= (err_r == ERR_NONE);
        out_err_r     <= err_r;
        out_address_r <= addr_r;
        out_moved_r   <= moved_r;
        out_used_r    <= used_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.clr_last   = (root_cnt_r == (RW + 1)'(ROOT_COUNT - 1));
    st.k_over     = (k_r > TOP_L);
    st.k_more     = ((33'd1 << ({1'b0, k_r} + {2'b0, bs_r})) < {1'b0, size_r});
    st.scan_done  = (root_cnt_r == (RW + 1)'(ROOT_COUNT));
    st.best_valid = best_valid_r;
    st.at_target  = (level_r <= k_r);
    st.node_free  = (mem_q_r == NODE_FREE);
    st.node_used  = (mem_q_r == NODE_USED);
    st.level_zero = (level_r == 5'd0);
    st.start_bad  = ((local_r & lmask) != '0);
    st.at_top     = (level_r == TOP_L);
    st.range_err  = ((off_r >> (TBL_L + {2'b0, bs_r})) != 32'd0);
    st.align_err  = ((off_r & ((32'd1 << bs_r) - 32'd1)) != 32'd0);
    st.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_error_code  = out_err_r;
  assign out_address     = out_address_r;
  assign out_moved_bytes = out_moved_r;
  assign out_used_total  = out_used_r;

  a_ok_matches_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ok_r == (out_err_r == ERR_NONE)))
    else $error("ok flag disagrees with error code");

  a_used_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_WR_USED |-> level_r <= k_r)
    else $error("block marked used above target level");

  a_pick_not_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PICK || cmd.op == OP_F_DESC || cmd.op == OP_WR_RFREE) |-> level_r != 5'd0)
    else $error("descent below leaf level");

  a_fail_moves_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_NONE) |-> out_moved_r == 29'd0)
    else $error("failed operation reports moved bytes");

endmodule

// ===== rtl/buddy_block_allocator_unit.sv =====
// Binary buddy allocator, best fit. An allocation rounds the size up, scans the ROOT_COUNT
// roots (one memory read each), walks down to the target level and refreshes the summaries
// on the way back up; a free checks the offset, walks down and merges on the way up. One
// transaction at a time, set by the node summary memory walk. After reset a clearing pass
// writes each of the ROOT_COUNT roots free before in_ready rises.
// Depends on bba_pkg, bba_ctrl, bba_datapath.
`timescale 1ns / 1ps

module buddy_block_allocator_unit #(
  parameter int TOTAL_BLOCKS_LOG2 = bba_pkg::TOTAL_BLOCKS_LOG2_DEF,
  parameter int MAX_ALLOC_LOG2    = bba_pkg::MAX_ALLOC_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_size_bytes,
  input  logic [31:0] in_offset,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [2:0]  out_error_code,
  output logic [27:0] out_address,
  output logic [28:0] out_moved_bytes,
  output logic [28:0] out_used_total,
  // block size register
  input  logic        cfg_write_en,
  input  logic [3:0]  cfg_write_data
);
  import bba_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer: clearing pass, size rounding, root scan, descent, merge walk,
  // then hold the transaction until the result register is free.
  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .st         (st),
    .cmd        (cmd)
  );

  // Datapath: summary memory, walk registers, used byte count, result register.
  // The result register lets a new transaction start while the last result waits.
  bba_datapath #(
    .TOTAL_BLOCKS_LOG2 (TOTAL_BLOCKS_LOG2),
    .MAX_ALLOC_LOG2    (MAX_ALLOC_LOG2)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_command      (in_command),
    .in_size_bytes   (in_size_bytes),
    .in_offset       (in_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_error_code  (out_error_code),
    .out_address     (out_address),
    .out_moved_bytes (out_moved_bytes),
    .out_used_total  (out_used_total)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the buddy block allocator: drives allocate and free
// transactions, predicts every result with an internal tree model, checks outputs.
// Depends on bba_pkg and buddy_block_allocator_unit.
`timescale 1ns / 1ps

typedef struct packed {
  logic        ok;
  logic [2:0]  err;
  logic [27:0] addr;
  logic [28:0] moved;
  logic [28:0] used;
} alloc_result_t;

// Holds expected results in arrival order and compares each observed one.
class alloc_result_board;
  alloc_result_t pending[$];
  int            failures;
  int            checked;

  function void note(alloc_result_t r);
    pending.push_back(r);
  endfunction

  function void check(alloc_result_t got);
    alloc_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result ok=%0d err=%0d addr=%h", $realtime, got.ok, got.err,
               got.addr);
      failures++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.ok !== want.ok) begin
      $display("%0t: ok expected %0d actual %0d", $realtime, want.ok, got.ok);
      failures++;
    end
    if (got.err !== want.err) begin
      $display("%0t: error_code expected %0d actual %0d", $realtime, want.err, got.err);
      failures++;
    end
    if (got.addr !== want.addr) begin
      $display("%0t: address expected %h actual %h", $realtime, want.addr, got.addr);
      failures++;
    end
    if (got.moved !== want.moved) begin
      $display("%0t: moved_bytes expected %h actual %h", $realtime, want.moved, got.moved);
      failures++;
    end
    if (got.used !== want.used) begin
      $display("%0t: used_total expected %h actual %h", $realtime, want.used, got.used);
      failures++;
    end
  endfunction
endclass

module testbench;
  import bba_pkg::*;

  localparam int TBL = 10;
  localparam int TOPL = 6;
  localparam int ROOTS = 1 << (TBL - TOPL);
  localparam int TNODES = (1 << (TOPL + 1)) - 1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [31:0] in_size_bytes;
  logic [31:0] in_offset;
  logic        out_valid;
  logic        out_ready;
  logic        out_ok;
  logic [2:0]  out_error_code;
  logic [27:0] out_address;
  logic [28:0] out_moved_bytes;
  logic [28:0] out_used_total;
  logic        cfg_write_en;
  logic [3:0]  cfg_write_data;

  buddy_block_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_size_bytes(in_size_bytes), .in_offset(in_offset),
    .out_valid(out_valid), .out_ready(out_ready), .out_ok(out_ok),
    .out_error_code(out_error_code), .out_address(out_address),
    .out_moved_bytes(out_moved_bytes), .out_used_total(out_used_total),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  alloc_result_board board;

  // Predictor state: one summary code per tree node, the used byte count, the register.
  logic [4:0]  tree[ROOTS][TNODES];
  logic [28:0] bytes_in_use;
  logic [3:0]  bs_reg;

  // Shadow of live allocations, used to aim frees at real blocks.
  logic [31:0] live_offs[$];
  logic        quiet;      // idling off for a stretch
  int          n_alloc, n_free, n_err;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int bs_eff();
    if (bs_reg < BS_MIN) return BS_MIN;
    if (bs_reg > BS_MAX) return BS_MAX;
    return bs_reg;
  endfunction

  // Largest free block of a node as log2, -1 when none.
  function automatic int free_lg(int rt, int hp, int lvl);
    logic [4:0] v;
    v = tree[rt][hp - 1];
    if (v[4]) return v[3:0];
    if (v == NODE_FREE) return lvl;
    return -1;
  endfunction

  function automatic void resummarize(int rt, int hp, int lvl);
    int l, r, m;
    l = free_lg(rt, 2 * hp, lvl - 1);
    r = free_lg(rt, 2 * hp + 1, lvl - 1);
    m = (l > r) ? l : r;
    tree[rt][hp - 1] = (m < 0) ? NODE_FRAG : (NODE_PARTIAL | m[4:0]);
  endfunction

  function automatic int carve(int rt, int hp, int lvl, int k);
    int l, r, side, res;
    if (lvl <= k) begin
      tree[rt][hp - 1] = NODE_USED;
      return hp;
    end
    if (tree[rt][hp - 1] == NODE_FREE) begin
      tree[rt][2 * hp - 1] = NODE_FREE;
      tree[rt][2 * hp] = NODE_FREE;
      tree[rt][hp - 1] = NODE_PARTIAL | 5'(lvl - 1);
    end
    l = free_lg(rt, 2 * hp, lvl - 1);
    r = free_lg(rt, 2 * hp + 1, lvl - 1);
    // smaller adequate child, left on a tie
    if (l <= r && l >= k) side = 0;
    else if (r < k) side = 0;
    else side = 1;
    res = carve(rt, 2 * hp + side, lvl - 1, k);
    resummarize(rt, hp, lvl);
    return res;
  endfunction

  function automatic int release_node(int rt, int hp, int lvl, int b, ref err_t err);
    logic [4:0] v;
    int res;
    v = tree[rt][hp - 1];
    if (v == NODE_USED) begin
      if ((b & ((1 << lvl) - 1)) != 0) begin
        err = ERR_NOT_START;
        return 0;
      end
      tree[rt][hp - 1] = NODE_FREE;
      return 1 << lvl;
    end
    if (v == NODE_FREE || lvl == 0) begin
      err = ERR_NOT_ALLOC;
      return 0;
    end
    res = release_node(rt, 2 * hp + ((b >> (lvl - 1)) & 1), lvl - 1, b, err);
    if (err != ERR_NONE) return 0;
    if (tree[rt][2 * hp - 1] == NODE_FREE && tree[rt][2 * hp] == NODE_FREE)
      tree[rt][hp - 1] = NODE_FREE;
    else
      resummarize(rt, hp, lvl);
    return res;
  endfunction

  // Compute the expected result of one accepted request and advance the model.
  function automatic alloc_result_t predict_alloc_step(
      logic cmd, logic [31:0] size, logic [31:0] off);
    alloc_result_t r;
    err_t err;
    int bs, k, best, bestl, f, hp;
    longint blk, total;
    logic [28:0] moved;
    bs = bs_eff();
    err = ERR_NONE;
    r = '0;
    moved = '0;
    if (cmd == CMD_ALLOC) begin
      k = 0;
      while (k < 40 && (64'd1 << (k + bs)) < {32'd0, size}) k++;
      if (k > TOPL) err = ERR_TOO_LARGE;
      else begin
        best = -1;
        bestl = 0;
        for (int rt = 0; rt < ROOTS; rt++) begin
          f = free_lg(rt, 1, TOPL);
          if (f >= k && (best < 0 || f < bestl)) begin
            best = rt;
            bestl = f;
          end
        end
        if (best < 0) err = ERR_NO_SPACE;
        else begin
          hp = carve(best, 1, TOPL, k);
          blk = (best << TOPL) + ((hp - (1 << (TOPL - k))) << k);
          r.addr = 28'(blk << bs);
          moved = 29'((64'd1 << k) << bs);
          bytes_in_use = bytes_in_use + moved;
          live_offs.push_back(32'(blk << bs));
        end
      end
    end else begin
      total = 64'd1 << (TBL + bs);
      if ({32'd0, off} >= total) err = ERR_RANGE;
      else if ((off & ((32'd1 << bs) - 1)) != 0) err = ERR_MISALIGN;
      else begin
        blk = off >> bs;
        f = release_node(int'(blk >> TOPL), 1, TOPL, int'(blk) & ((1 << TOPL) - 1), err);
        if (err == ERR_NONE) begin
          moved = 29'(longint'(f) << bs);
          bytes_in_use = (bytes_in_use >= moved) ? bytes_in_use - moved : '0;
          foreach (live_offs[i]) if (live_offs[i] == off) begin
            live_offs.delete(i);
            break;
          end
        end
      end
    end
    r.ok = (err == ERR_NONE);
    r.err = err;
    r.moved = moved;
    r.used = bytes_in_use;
    if (err == ERR_NONE) begin
      if (cmd == CMD_ALLOC) n_alloc++;
      else n_free++;
    end else n_err++;
    return r;
  endfunction

  // Present one transaction, hold it until accepted, then note its prediction.
  // Valid stays up past the accepting edge; the next falling edge either drops it
  // or replaces the payload with the next transaction.
  task automatic send_request(logic cmd, logic [31:0] size, logic [31:0] off);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_size_bytes <= size;
    in_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note(predict_alloc_step(cmd, size, off));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  // Write the block size register while the block is idle.
  task automatic set_block_size(logic [3:0] v);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    bs_reg = v;
  endtask

  task automatic send_alloc(logic [31:0] size);
    send_request(CMD_ALLOC, size, $urandom);
  endtask

  task automatic send_free(logic [31:0] off);
    send_request(CMD_FREE, $urandom, off);
  endtask

  // Random mix: mostly real allocate/free pairs, the rest malformed frees.
  task automatic random_phase(int count);
    int bs, pick;
    logic [31:0] off;
    for (int i = 0; i < count; i++) begin
      bs = bs_eff();
      quiet = (i >= count / 3 && i < count / 3 + 60);
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) send_alloc($urandom);
        else send_alloc($urandom_range((1 << (bs + $urandom_range(TOPL))), 0));
      end else if (pick < 85 && live_offs.size() != 0) begin
        off = live_offs[$urandom_range(live_offs.size() - 1)];
        send_free(off);
      end else if (pick < 92 && live_offs.size() != 0) begin
        off = live_offs[$urandom_range(live_offs.size() - 1)];
        send_free(off + (32'd1 << (bs + $urandom_range(TOPL - 1))));
      end else begin
        case ($urandom_range(2))
          0: send_free($urandom);
          1: send_free($urandom_range((1 << (TBL + bs)) - 1, 0));
          default: send_free($urandom_range((1 << TBL) - 1, 0) << bs);
        endcase
      end
    end
    quiet = 1'b0;
  endtask

  // Random output stall, with a stall-free stretch a third of the way into each random phase.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check({out_ok, out_error_code, out_address, out_moved_bytes, out_used_total});
  end

  initial begin
    board = new();
    foreach (tree[r, n]) tree[r][n] = NODE_FREE;
    bytes_in_use = '0;
    bs_reg = BS_RESET;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ALLOC;
    in_size_bytes = '0;
    in_offset = '0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero size, exact and rounded sizes, maximum, too large, bad frees.
    send_alloc(32'd0);
    send_alloc(32'd17);
    send_alloc(32'd1024);
    send_alloc(32'd1025);
    send_alloc(32'hFFFF_FFFF);
    send_free(32'hFFFF_FFFF);
    send_free(32'd16384);
    send_free(32'd3);
    send_free(32'd1024 + 32'd16);
    send_free(32'd8192);
    send_free(32'd0);
    send_free(32'd0);
    send_free(32'd16);
    for (int i = 0; i < 17; i++) send_alloc(32'd1024);
    // Maximum blocks now fill every root but root 0, where a one-byte allocation still fits.
    send_alloc(32'd1);

    // Hold the sender until everything has come back.
    drain();
    for (int i = 0; i < 16; i++) send_free(32'(i * 1024));
    send_free(32'd4096);

    set_block_size(4'd0);
    random_phase(300);
    set_block_size(4'd15);
    random_phase(250);
    set_block_size(4'd12);
    random_phase(250);
    set_block_size(4'd2);
    random_phase(450);
    set_block_size(4'd7);
    random_phase(400);

    drain();
    $display("Covered %0d allocations, %0d frees, %0d rejected requests, %0d results checked.",
             n_alloc, n_free, n_err, board.checked);
    $display("Block size register swept across 0, 2, 7, 12 and 15.");
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
